@@ rtl/tpd_pkg.sv @@
`timescale 1ns / 1ps

package tpd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_PRESS_DB    = 2'd1;
    localparam logic [1:0] CFG_RELEASE_DB  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [10:0] THRESHOLD_RESET  = 11'd50;
    localparam logic [15:0] PRESS_DB_RESET   = 16'd10;
    localparam logic [15:0] RELEASE_DB_RESET = 16'd25;

    // Coordinate value before the first touch
    localparam logic signed [11:0] POS_NONE = -12'sd1;

    // Debounce phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'b0001,
        PH_DB_PRESS   = 4'b0010,
        PH_PRESSED    = 4'b0100,
        PH_DB_RELEASE = 4'b1000
    } phase_t;

    // Input request payload
    typedef struct packed {
        logic [31:0] now_ms;
        logic [7:0]  pressure_high;
        logic [7:0]  pressure_low;
        logic [7:0]  xpos_high;
        logic [7:0]  xpos_low;
        logic [7:0]  ypos_high;
        logic [7:0]  ypos_low;
    } in_t;

    // Result request payload
    typedef struct packed {
        logic              is_pressed;
        logic signed [11:0] xpos_out;
        logic signed [11:0] ypos_out;
        logic [10:0]       pressure_out;
    } out_t;

    // Configuration values seen by the tracker
    typedef struct packed {
        logic [10:0] pressure_threshold;
        logic [15:0] press_debounce_ms;
        logic [15:0] release_debounce_ms;
    } cfg_t;

    // Tracker state exported for checking
    typedef struct packed {
        phase_t      phase;
        logic [31:0] deadline_ms;
    } track_state_t;

    // Reading formed as (high << 3) | low
    function automatic logic [10:0] join_bytes(input logic [7:0] hi, input logic [7:0] lo);
        join_bytes = {hi, 3'b000} | {3'b000, lo};
    endfunction

endpackage

@@ rtl/tpd_cfg_regs.sv @@
`timescale 1ns / 1ps

module tpd_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output tpd_pkg::cfg_t       cfg
);

    logic [10:0] threshold_reg;
    logic [15:0] press_db_reg;
    logic [15:0] release_db_reg;

    // Register writes; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= tpd_pkg::THRESHOLD_RESET;
            press_db_reg   <= tpd_pkg::PRESS_DB_RESET;
            release_db_reg <= tpd_pkg::RELEASE_DB_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tpd_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data[10:0];
                tpd_pkg::CFG_PRESS_DB:   press_db_reg   <= cfg_data;
                tpd_pkg::CFG_RELEASE_DB: release_db_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.pressure_threshold  = threshold_reg;
    assign cfg.press_debounce_ms   = press_db_reg;
    assign cfg.release_debounce_ms = release_db_reg;

endmodule

@@ rtl/tpd_track.sv @@
`timescale 1ns / 1ps

module tpd_track
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  tpd_pkg::in_t           sample,
    input  tpd_pkg::cfg_t          cfg,
    output tpd_pkg::out_t          result,
    output tpd_pkg::track_state_t  state
);

    tpd_pkg::phase_t   phase_reg, phase_next, phase_ev;
    logic [31:0]       deadline_reg, deadline_next, deadline_ev;
    logic signed [11:0] xpos_reg, xpos_next;
    logic signed [11:0] ypos_reg, ypos_next;
    logic [10:0]       pressure;
    logic              touched;
    logic              arm;
    logic [15:0]       span;
    logic [31:0]       armed_sum;
    logic [31:0]       elapsed;
    logic              expired;

    // Readings and coordinate latch
    always_comb
    begin
        pressure  = tpd_pkg::join_bytes(sample.pressure_high, sample.pressure_low);
        touched   = pressure > cfg.pressure_threshold;
        xpos_next = touched
                  ? $signed({1'b0, tpd_pkg::join_bytes(sample.xpos_high, sample.xpos_low)})
                  : xpos_reg;
        ypos_next = touched
                  ? $signed({1'b0, tpd_pkg::join_bytes(sample.ypos_high, sample.ypos_low)})
                  : ypos_reg;
    end

    // Touch event, then deadline test
    always_comb
    begin
        phase_ev    = phase_reg;
        deadline_ev = deadline_reg;
        arm         = 1'b0;
        span        = cfg.press_debounce_ms;
        unique case (phase_reg)
            tpd_pkg::PH_IDLE:
            begin
                if (touched)
                begin
                    phase_ev = tpd_pkg::PH_DB_PRESS;
                    arm      = 1'b1;
                    span     = cfg.press_debounce_ms;
                end
            end
            tpd_pkg::PH_PRESSED:
            begin
                if (!touched)
                begin
                    phase_ev = tpd_pkg::PH_DB_RELEASE;
                    arm      = 1'b1;
                    span     = cfg.release_debounce_ms;
                end
            end
            tpd_pkg::PH_DB_PRESS:
            begin
                if (!touched)
                begin
                    phase_ev    = tpd_pkg::PH_IDLE;
                    deadline_ev = 32'd0;
                end
            end
            tpd_pkg::PH_DB_RELEASE:
            begin
                if (touched)
                begin
                    phase_ev    = tpd_pkg::PH_PRESSED;
                    deadline_ev = 32'd0;
                end
            end
            default:
            begin
                phase_ev    = tpd_pkg::PH_IDLE;
                deadline_ev = 32'd0;
            end
        endcase

        // zero means no deadline, so bump it to one
        armed_sum = sample.now_ms + {16'd0, span};
        if (arm)
        begin
            deadline_ev = (armed_sum == 32'd0) ? 32'd1 : armed_sum;
        end

        // wrapping signed compare
        elapsed = sample.now_ms - deadline_ev;
        expired = (deadline_ev != 32'd0) && !elapsed[31];

        phase_next    = phase_ev;
        deadline_next = deadline_ev;
        if (expired)
        begin
            deadline_next = 32'd0;
            if (phase_ev == tpd_pkg::PH_DB_PRESS)
            begin
                phase_next = tpd_pkg::PH_PRESSED;
            end
            else if (phase_ev == tpd_pkg::PH_DB_RELEASE)
            begin
                phase_next = tpd_pkg::PH_IDLE;
            end
        end
    end

    // State update once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tpd_pkg::PH_IDLE;
            deadline_reg <= 32'd0;
            xpos_reg     <= tpd_pkg::POS_NONE;
            ypos_reg     <= tpd_pkg::POS_NONE;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
            xpos_reg     <= xpos_next;
            ypos_reg     <= ypos_next;
        end
    end

    assign result.is_pressed   = (phase_next == tpd_pkg::PH_PRESSED);
    assign result.xpos_out     = xpos_next;
    assign result.ypos_out     = ypos_next;
    assign result.pressure_out = pressure;

    assign state.phase       = phase_reg;
    assign state.deadline_ms = deadline_reg;

endmodule

@@ rtl/touch_press_debouncer_core.sv @@
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    in_data  (tpd_pkg::in_t)
// out      out_valid / out_ready  out_data (tpd_pkg::out_t)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle sustained while out_ready is high; a request accepted
// into the input register passes to the result register once that register is free.
// The debounce update sits between the input register and the result register.
// rst_n resets the phase, deadline, coordinates and configuration at once.
// A stalled result holds the input register; cfg is always ready.

module touch_press_debouncer_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tpd_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tpd_pkg::out_t    out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    logic                  s1_valid_reg;
    tpd_pkg::in_t          s1_data_reg;
    logic                  out_valid_reg;
    tpd_pkg::out_t         out_data_reg;
    logic                  s1_fire;
    tpd_pkg::cfg_t         cfg;
    tpd_pkg::out_t         result;
    tpd_pkg::track_state_t trk_state;

    assign cfg_ready = 1'b1;

    // Pipeline handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    tpd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpd_track u_track
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_fire),
        .sample  (s1_data_reg),
        .cfg     (cfg),
        .result  (result),
        .state   (trk_state)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(trk_state.phase))
        else $error("debounce phase not one-hot");

    a_settled_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        (trk_state.phase == tpd_pkg::PH_IDLE || trk_state.phase == tpd_pkg::PH_PRESSED)
        |-> (trk_state.deadline_ms == 32'd0))
        else $error("deadline armed in a settled phase");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid)
        else $error("processed sample produced no result");

    a_stall_holds_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("stalled sample lost");

endmodule
